FILE: hdl/fba_pkg.sv
`default_nettype none
package fba_pkg;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int CNT_W          = 13;
  localparam int FRAME_W        = 12;
  localparam int ACT_W          = 2;
  localparam int STAT_W         = 2;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;

  localparam logic [CNT_W-1:0] RESET_COUNT = 13'd4096;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTHING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [FRAME_W-1:0] page_frame_in;
    logic [FRAME_W-1:0] frame_index;
    logic               kernel_page;
    logic               want_write;
  } fba_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame_out;
    logic               present;
    logic               writable;
    logic               user_page;
    logic               frame_used;
  } fba_res_t;

endpackage
`default_nettype wire

FILE: hdl/fba_ram.sv
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/fba_zfind.sv
`default_nettype none
module fba_zfind import fba_pkg::*; (
  input  wire logic [WORD_W-1:0] word,
  output logic                   found,
  output logic [BIT_W-1:0]       idx
);

  always_comb begin
    found = ~&word;
    idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fba_seq.sv
`default_nettype none
module fba_seq import fba_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] frame_count,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire fba_req_t         req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output fba_res_t              res
);

  localparam int WORDS = (MAX_FRAMES + 31) / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW    = AW + BIT_W;
  localparam int CMPW  = (FW > CNT_W) ? FW : CNT_W;
  localparam int MAXC  = (MAX_FRAMES < (2 ** CNT_W - 1)) ? MAX_FRAMES : (2 ** CNT_W - 1);
  localparam logic [CNT_W-1:0] MAX_C     = CNT_W'(MAXC);
  localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_FREE_WR = 3'd2;
  localparam logic [2:0] S_TEST_EV = 3'd3;
  localparam logic [2:0] S_RES     = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    w_r, w_nxt;
  logic [AW-1:0]    rd_w_r, rd_w_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             iss_end_r, iss_end_nxt;
  logic [AW:0]      hwm_r, hwm_nxt;
  logic [AW-1:0]    word_r, word_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             kern_r, kern_nxt;
  logic             wr_r, wr_nxt;
  fba_res_t         res_r, res_nxt;

  logic [CNT_W-1:0]  eff;
  logic [CMPW-1:0]   eff_x;
  logic [CMPW-1:0]   pfin_x;
  logic [CMPW-1:0]   fidx_x;
  logic [CMPW-1:0]   scan_x;
  logic [CMPW-1:0]   hit_x;
  logic [AW-1:0]     pfin_w;
  logic [AW-1:0]     fidx_w;
  logic              iss;
  logic [WORD_W-1:0] scan_data;
  logic              zf_found;
  logic [BIT_W-1:0]  zf_idx;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_q;

  fba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  fba_zfind u_zfind (
    .word  (scan_data),
    .found (zf_found),
    .idx   (zf_idx)
  );

  assign eff       = (frame_count > MAX_C) ? MAX_C : frame_count;
  assign eff_x     = CMPW'(eff);
  assign pfin_x    = CMPW'(req.page_frame_in);
  assign fidx_x    = CMPW'(req.frame_index);
  assign pfin_w    = pfin_x[FW-1:BIT_W];
  assign fidx_w    = fidx_x[FW-1:BIT_W];
  assign scan_x    = CMPW'({w_r, {BIT_W{1'b0}}});
  assign hit_x     = CMPW'({rd_w_r, zf_idx});
  assign iss       = !iss_end_r && (scan_x < eff_x);
  assign scan_data = ({1'b0, rd_w_r} < hwm_r) ? ram_q : '0;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    w_nxt       = w_r;
    rd_w_nxt    = rd_w_r;
    rd_vld_nxt  = rd_vld_r;
    iss_end_nxt = iss_end_r;
    hwm_nxt     = hwm_r;
    word_nxt    = word_r;
    bit_nxt     = bit_r;
    kern_nxt    = kern_r;
    wr_nxt      = wr_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = rd_w_r;
    ram_wdata   = scan_data | (WORD_W'(1) << zf_idx);
    ram_raddr   = w_r;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = (req.action == ACT_TEST) ? fidx_w : pfin_w;
        if (req_valid) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOTHING;
          kern_nxt       = req.kernel_page;
          wr_nxt         = req.want_write;
          state_nxt      = S_RES;
          unique case (req.action)
            ACT_ALLOC: begin
              if (req.page_frame_in != '0) begin
                res_nxt.frame_out = req.page_frame_in;
              end else begin
                w_nxt       = '0;
                rd_vld_nxt  = 1'b0;
                iss_end_nxt = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            ACT_FREE: begin
              word_nxt = pfin_w;
              bit_nxt  = pfin_x[BIT_W-1:0];
              if (req.page_frame_in == '0) begin
                res_nxt.status = ST_NOTHING;
              end else if (pfin_x >= eff_x) begin
                res_nxt.status    = ST_RANGE;
                res_nxt.frame_out = req.page_frame_in;
              end else begin
                res_nxt.status = ST_DONE;
                if ({1'b0, pfin_w} < hwm_r) begin
                  state_nxt = S_FREE_WR;
                end
              end
            end
            ACT_TEST: begin
              word_nxt = fidx_w;
              bit_nxt  = fidx_x[BIT_W-1:0];
              if (fidx_x >= eff_x) begin
                res_nxt.status = ST_RANGE;
              end else begin
                res_nxt.status = ST_DONE;
                if ({1'b0, fidx_w} < hwm_r) begin
                  state_nxt = S_TEST_EV;
                end
              end
            end
            default: begin
              res_nxt.status = ST_NOTHING;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld_r && zf_found) begin
          state_nxt = S_RES;
          if (hit_x >= eff_x) begin
            res_nxt.status = ST_FULL;
          end else begin
            ram_we            = 1'b1;
            res_nxt.status    = ST_DONE;
            res_nxt.frame_out = hit_x[FRAME_W-1:0];
            res_nxt.present   = 1'b1;
            res_nxt.writable  = wr_r;
            res_nxt.user_page = ~kern_r;
            if ({1'b0, rd_w_r} == hwm_r) begin
              hwm_nxt = hwm_r + (AW+1)'(1);
            end
          end
        end else if (rd_vld_r || iss) begin
          rd_vld_nxt = iss;
          rd_w_nxt   = w_r;
          if (iss) begin
            w_nxt       = w_r + AW'(1);
            iss_end_nxt = (w_r == LAST_WORD);
          end
        end else begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_RES;
        end
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = word_r;
        ram_wdata = ram_q & ~(WORD_W'(1) << bit_r);
        state_nxt = S_RES;
      end
      S_TEST_EV: begin
        res_nxt.frame_used = ram_q[bit_r];
        state_nxt          = S_RES;
      end
      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hwm_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hwm_r    <= hwm_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    w_r       <= w_nxt;
    rd_w_r    <= rd_w_nxt;
    iss_end_r <= iss_end_nxt;
    word_r    <= word_nxt;
    bit_r     <= bit_nxt;
    kern_r    <= kern_nxt;
    wr_r      <= wr_nxt;
    res_r     <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/frame_bitmap_allocator_unit.sv
// channel  | direction | handshake         | payload
// in_      | slave     | in_tvalid/tready  | in_tuser: action; in_tdata: item fields
// out_     | master    | out_tvalid/tready | out_tdata: result fields
// cfg_     | slave     | cfg_valid/ready   | cfg_data: frame_count
//
// Allocate reads one bitmap word per cycle, at most ceil(frame_count / 32) words, and stops at
// the first word with a clear bit; no clear bit below frame_count gives a full reply.
// Free and test read the RAM word only when in range and the word was ever written.
// Already mapped and unknown actions go straight to the reply.
// A fill count marks words never written as free, so reset needs no clear pass.
// A finished beat waits in the output register; a second result holds in_tready low.
`default_nettype none
module frame_bitmap_allocator_unit import fba_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,  // page_frame_in[11:0], frame_index[23:12],
                                           // kernel_page[24], want_write[25]
  input  wire logic [1:0]       in_tuser,  // action[1:0]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata, // status[1:0], frame_out[13:2], present[14],
                                           // writable[15], user_page[16], frame_used[17]
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] frame_count_r;
  logic             out_tvalid_r, out_tvalid_nxt;
  fba_res_t         out_res_r;
  fba_req_t         req;
  fba_res_t         res;
  logic             res_valid;
  logic             res_ready;

  assign req.action        = in_tuser;
  assign req.page_frame_in = in_tdata[11:0];
  assign req.frame_index   = in_tdata[23:12];
  assign req.kernel_page   = in_tdata[24];
  assign req.want_write    = in_tdata[25];

  fba_seq #(.MAX_FRAMES(MAX_FRAMES)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_count (frame_count_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= RESET_COUNT;
      out_tvalid_r  <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        frame_count_r <= cfg_data;
      end
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_res_r.frame_used, out_res_r.user_page, out_res_r.writable,
                       out_res_r.present, out_res_r.frame_out, out_res_r.status};

endmodule
`default_nettype wire

FILE: hdl/fba_checker.sv
`default_nettype none
module fba_checker import fba_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed while stalled");

  a_present_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> out_tdata[1:0] == ST_DONE)
    else $error("present set without done status");

  a_used_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[1:0] == ST_DONE && !out_tdata[14])
    else $error("frame_used set on a non-test result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new beat taken while an item is in progress");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: dv/frame_bitmap_allocator_unit_tb.sv
`default_nettype none
module frame_bitmap_allocator_unit_tb;
  import fba_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int NFRAMES    = MAX_FRAMES_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 250;
  localparam int TAIL_WAIT  = 140;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;
  logic [1:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [23:0]      out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  bit [NFRAMES-1:0] frame_in_use;
  logic [CNT_W-1:0] frame_limit;
  int               held_frames[$];
  fba_res_t         pending_entries[$];

  bit calm;
  bit hold_req;
  int errors;
  int items_sent;
  int beats_checked;
  int settings_seen;
  int n_alloc;
  int n_full;
  int n_range;

  frame_bitmap_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int active_frames();
    return (int'(frame_limit) < NFRAMES) ? int'(frame_limit) : NFRAMES;
  endfunction

  function automatic fba_res_t page_entry_after(input fba_req_t r);
    fba_res_t e;
    int       lim;
    int       f;
    int       idx;
    bit       found;
    e = '0;
    e.status = ST_NOTHING;
    lim = active_frames();
    found = 1'b0;
    case (r.action)
      ACT_ALLOC: begin
        if (r.page_frame_in != '0) begin
          e.frame_out = r.page_frame_in;
        end else begin
          for (f = 0; f < lim && !found; f++) begin
            if (!frame_in_use[f]) begin
              found = 1'b1;
              idx = f;
            end
          end
          if (found) begin
            frame_in_use[idx] = 1'b1;
            held_frames.push_back(idx);
            e.status    = ST_DONE;
            e.frame_out = idx[FRAME_W-1:0];
            e.present   = 1'b1;
            e.writable  = r.want_write;
            e.user_page = ~r.kernel_page;
            n_alloc++;
          end else begin
            e.status = ST_FULL;
            n_full++;
          end
        end
      end
      ACT_FREE: begin
        if (r.page_frame_in == '0) begin
          e.status = ST_NOTHING;
        end else if (int'(r.page_frame_in) >= lim) begin
          e.status    = ST_RANGE;
          e.frame_out = r.page_frame_in;
          n_range++;
        end else begin
          frame_in_use[r.page_frame_in] = 1'b0;
          held_frames = held_frames.find(x) with (x != int'(r.page_frame_in));
          e.status = ST_DONE;
        end
      end
      ACT_TEST: begin
        if (int'(r.frame_index) >= lim) begin
          e.status = ST_RANGE;
          n_range++;
        end else begin
          e.status     = ST_DONE;
          e.frame_used = frame_in_use[r.frame_index];
        end
      end
      default: e.status = ST_NOTHING;
    endcase
    return e;
  endfunction

  function automatic fba_req_t make_req(input logic [ACT_W-1:0] act,
                                        input int pfin, input int fidx,
                                        input bit kern, input bit wr);
    fba_req_t r;
    r.action        = act;
    r.page_frame_in = pfin[FRAME_W-1:0];
    r.frame_index   = fidx[FRAME_W-1:0];
    r.kernel_page   = kern;
    r.want_write    = wr;
    return r;
  endfunction

  function automatic fba_req_t random_req(input int alloc_pct);
    fba_req_t r;
    int       pick;
    int       lim;
    r = make_req(ACT_ALLOC, 0, int'($urandom_range(0, NFRAMES - 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    lim = active_frames();
    pick = int'($urandom_range(0, 99));
    if (pick < alloc_pct) begin
      r.action = ACT_ALLOC;
    end else if (pick < alloc_pct + 20) begin
      r.action = ACT_FREE;
      if (held_frames.size() != 0)
        r.page_frame_in = FRAME_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
      else
        r.page_frame_in = FRAME_W'($urandom_range(1, NFRAMES - 1));
    end else if (pick < alloc_pct + 35) begin
      r.action = ACT_TEST;
      pick = int'($urandom_range(0, 3));
      if (pick < 2 && held_frames.size() != 0)
        r.frame_index = FRAME_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
      else if (pick == 2 && lim > 0)
        r.frame_index = FRAME_W'($urandom_range(0, lim - 1));
    end else begin
      r.action        = ACT_W'($urandom_range(0, 3));
      r.page_frame_in = FRAME_W'($urandom_range(0, NFRAMES - 1));
    end
    return r;
  endfunction

  task automatic log_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got !== want)
      log_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                          beats_checked, name, got, want));
  endtask

  // hold valid high across back-to-back beats; lower it only ahead of a gap
  task automatic send_req(input fba_req_t r);
    bit taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.action;
    in_tdata  <= {6'd0, r.want_write, r.kernel_page, r.frame_index, r.page_frame_in};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    pending_entries.push_back(page_entry_after(r));
    items_sent++;
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_count(input int value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid   <= 1'b0;
    frame_limit = value[CNT_W-1:0];
    settings_seen++;
    @(posedge clk);
  endtask

  task automatic test_reset_map();
    send_req(make_req(ACT_ALLOC, 0, 0, 1'b1, 1'b0));
    send_req(make_req(ACT_ALLOC, 0, 4095, 1'b0, 1'b1));
    send_req(make_req(ACT_ALLOC, 4095, 0, 1'b0, 1'b1));
    send_req(make_req(ACT_TEST, 0, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_TEST, 0, 4095, 1'b1, 1'b1));
    send_req(make_req(ACT_FREE, 0, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_FREE, 1, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_FREE, 1, 0, 1'b1, 1'b1));
    send_req(make_req(ACT_TEST, 0, 1, 1'b0, 1'b0));
    send_req(make_req(ACT_NONE, 4095, 4095, 1'b1, 1'b1));
    send_req(make_req(ACT_ALLOC, 0, 0, 1'b0, 1'b0));
    drop_valid();
    drain_results();
  endtask

  task automatic test_limit_edges();
    write_frame_count(1);
    send_req(make_req(ACT_ALLOC, 0, 0, 1'b0, 1'b1));
    send_req(make_req(ACT_TEST, 0, 1, 1'b0, 1'b0));
    send_req(make_req(ACT_TEST, 0, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_FREE, 1, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_FREE, 4095, 0, 1'b0, 1'b0));
    drop_valid();
    drain_results();
    write_frame_count(0);
    send_req(make_req(ACT_ALLOC, 0, 0, 1'b1, 1'b1));
    send_req(make_req(ACT_TEST, 0, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_FREE, 5, 0, 1'b0, 1'b0));
    drop_valid();
    drain_results();
    write_frame_count(8191);
    send_req(make_req(ACT_TEST, 0, 4095, 1'b0, 1'b0));
    send_req(make_req(ACT_FREE, 4095, 0, 1'b0, 1'b0));
    send_req(make_req(ACT_ALLOC, 0, 0, 1'b1, 1'b0));
    drop_valid();
    drain_results();
  endtask

  task automatic test_random_traffic(input int limit, input int count, input int alloc_pct);
    write_frame_count(limit);
    repeat (count) send_req(random_req(alloc_pct));
    drop_valid();
    drain_results();
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (30) send_req(random_req(50));
    drop_valid();
    drain_results();
  endtask

  task automatic test_steady_tail();
    calm = 1'b1;
    write_frame_count(4096);
    repeat (60) send_req(random_req(45));
    drop_valid();
  endtask

  // sink: random stall bursts, plus one long hold on request
  initial begin : sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = int'($urandom_range(1, 14)) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : check_results
    fba_res_t got;
    fba_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = out_tdata[1:0];
      got.frame_out  = out_tdata[13:2];
      got.present    = out_tdata[14];
      got.writable   = out_tdata[15];
      got.user_page  = out_tdata[16];
      got.frame_used = out_tdata[17];
      if (pending_entries.size() == 0) begin
        log_error($sformatf("result beat 0x%06h with nothing expected", out_tdata));
      end else begin
        want = pending_entries.pop_front();
        check_field("status", int'(got.status), int'(want.status));
        check_field("frame_out", int'(got.frame_out), int'(want.frame_out));
        check_field("present", int'(got.present), int'(want.present));
        check_field("writable", int'(got.writable), int'(want.writable));
        check_field("user_page", int'(got.user_page), int'(want.user_page));
        check_field("frame_used", int'(got.frame_used), int'(want.frame_used));
      end
      beats_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no beat for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, pending_entries.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    calm          = 1'b0;
    hold_req      = 1'b0;
    errors        = 0;
    items_sent    = 0;
    beats_checked = 0;
    settings_seen = 0;
    n_alloc       = 0;
    n_full        = 0;
    n_range       = 0;
    frame_in_use  = '0;
    frame_limit   = RESET_COUNT;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_map();
    test_limit_edges();
    test_random_traffic(40, 70, 60);
    test_random_traffic(4096, 60, 45);
    test_random_traffic(100, 60, 50);
    test_random_traffic(8191, 50, 40);
    test_random_traffic(int'($urandom_range(1, 4096)), 50, 45);
    test_random_traffic(33, 70, 70);
    test_output_stall();
    test_steady_tail();

    while (pending_entries.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("sent %0d requests over %0d frame_count writes, %0d results checked",
             items_sent, settings_seen, beats_checked);
    $display("%0d frames handed out, %0d map-full, %0d out-of-range replies",
             n_alloc, n_full, n_range);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hdl/fba_pkg.sv
hdl/fba_ram.sv
hdl/fba_zfind.sv
hdl/fba_seq.sv
hdl/frame_bitmap_allocator_unit.sv
hdl/fba_checker.sv
dv/frame_bitmap_allocator_unit_tb.sv
